// File: rtl/ust_pkg.sv
// shared types and codes for the unordered set table
// no dependencies; used by ust_cell and unordered_set_table
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

    // request function codes
    localparam logic [2:0] FN_APPEND   = 3'd0;
    localparam logic [2:0] FN_DELETE   = 3'd1;
    localparam logic [2:0] FN_REMOVE   = 3'd2;
    localparam logic [2:0] FN_CONTAINS = 3'd3;
    localparam logic [2:0] FN_TAKE     = 3'd4;
    localparam logic [2:0] FN_CLEAR    = 3'd5;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_INSERT = 2'd1;
    localparam logic [1:0] EV_REMOVE = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] item_value;
        logic [5:0]  index;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [1:0]  event_res;
        logic [31:0] result_item;
        logic [5:0]  position;
        logic        found;
        logic [6:0]  count;
        logic        last_in_run;
    } t_rsp;

    // write controls broadcast to every cell
    typedef struct packed {
        logic en;
        logic shift;
    } t_wr_ctl;

    // search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } t_probe_ctl;

endpackage

`default_nettype wire

// File: rtl/ust_cell.sv
// one slot of the set table: holds an entry and passes the search token on
// depends on ust_pkg
`timescale 1ns / 1ps
`default_nettype none

module ust_cell #(
    parameter int IDX        = 0,
    parameter int ITEM_WIDTH = 32,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ust_pkg::t_wr_ctl      i_wr,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [ITEM_WIDTH-1:0] i_wr_data,
    input  wire logic [ITEM_WIDTH-1:0] i_prev_entry,
    input  wire logic                  i_by_value,
    input  wire logic [ITEM_WIDTH-1:0] i_key,
    input  wire logic [AW-1:0]         i_target,
    input  wire logic [CW-1:0]         i_count,
    input  wire ust_pkg::t_probe_ctl   i_probe,
    input  wire logic [ITEM_WIDTH-1:0] i_probe_item,
    input  wire logic [ITEM_WIDTH-1:0] i_probe_last,
    input  wire logic [AW-1:0]         i_probe_pos,
    output ust_pkg::t_probe_ctl        o_probe,
    output logic [ITEM_WIDTH-1:0]      o_probe_item,
    output logic [ITEM_WIDTH-1:0]      o_probe_last,
    output logic [AW-1:0]              o_probe_pos,
    output logic [ITEM_WIDTH-1:0]      o_entry
);

    localparam logic [AW-1:0] MY_POS = AW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [ITEM_WIDTH-1:0] r_entry;
    ust_pkg::t_probe_ctl   r_probe;
    logic [ITEM_WIDTH-1:0] r_probe_item;
    logic [ITEM_WIDTH-1:0] r_probe_last;
    logic [AW-1:0]         r_probe_pos;

    logic w_in_use;
    logic w_match;
    logic w_take;
    logic w_is_last;

    assign w_in_use  = (MY_CNT < i_count);
    assign w_match   = i_by_value ? (r_entry == i_key) : (MY_POS == i_target);
    // first matching slot wins
    assign w_take    = i_probe.valid && !i_probe.hit && w_in_use && w_match;
    assign w_is_last = (MY_CNT == CW'(i_count - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (i_wr.shift) begin
            r_entry <= i_prev_entry;
        end else if (i_wr.en && (i_wr_addr == MY_POS)) begin
            r_entry <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe.valid <= i_probe.valid;
            r_probe.hit   <= i_probe.hit | w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe_item <= w_take ? r_entry : i_probe_item;
        r_probe_pos  <= w_take ? MY_POS : i_probe_pos;
        r_probe_last <= (i_probe.valid && w_is_last) ? r_entry : i_probe_last;
    end

    assign o_probe      = r_probe;
    assign o_probe_item = r_probe_item;
    assign o_probe_last = r_probe_last;
    assign o_probe_pos  = r_probe_pos;
    assign o_entry      = r_entry;

endmodule

`default_nettype wire

// File: rtl/unordered_set_table.sv
// unordered set table top: control sequencer over a row of ust_cell slots
// depends on ust_pkg and ust_cell
// append, bad func, failing delete/take and empty clear: result in the cycle after start, busy stays low
// delete, remove and contains: one search token walking the cell row
// take: reduces the cursor modulo count by repeated subtraction before the walk
// clear of n items: slot 0 result first, then the other n-1 at one result per cycle, results never stall;
// reset empties the set
`timescale 1ns / 1ps
`default_nettype none

module unordered_set_table #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ust_pkg::t_req i_req,
    output logic               o_rsp_valid,
    output ust_pkg::t_rsp      o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 6) ? CW : 6;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_SWEEP = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_skip, n_skip;
    logic [2:0]            r_func, n_func;
    logic [ITEM_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]         r_target, n_target;
    logic                  r_by_value, n_by_value;
    logic                  r_launch, n_launch;
    logic                  r_rsp_valid, n_rsp_valid;
    ust_pkg::t_rsp         r_rsp, n_rsp;

    ust_pkg::t_wr_ctl      w_wr;
    logic [AW-1:0]         w_wr_addr;
    logic [ITEM_WIDTH-1:0] w_wr_data;
    logic [ITEM_WIDTH-1:0] w_key_in;

    logic [ITEM_WIDTH-1:0] w_entry      [CAPACITY];
    ust_pkg::t_probe_ctl   w_probe_ctl  [CAPACITY+1];
    logic [ITEM_WIDTH-1:0] w_probe_item [CAPACITY+1];
    logic [ITEM_WIDTH-1:0] w_probe_last [CAPACITY+1];
    logic [AW-1:0]         w_probe_pos  [CAPACITY+1];

    function automatic ust_pkg::t_rsp f_rsp(
        input logic                  status,
        input logic [1:0]            ev,
        input logic [ITEM_WIDTH-1:0] item,
        input logic [AW-1:0]         pos,
        input logic                  found,
        input logic [CW-1:0]         cnt,
        input logic                  last
    );
        ust_pkg::t_rsp rsp;
        rsp.status      = status;
        rsp.event_res   = ev;
        rsp.result_item = 32'(item);
        rsp.position    = 6'(pos);
        rsp.found       = found;
        rsp.count       = 7'(cnt);
        rsp.last_in_run = last;
        return rsp;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign w_key_in = ITEM_WIDTH'(i_req.item_value);

    // search token enters the row at slot 0
    assign w_probe_ctl[0]  = '{valid: r_launch, hit: 1'b0};
    assign w_probe_item[0] = '0;
    assign w_probe_last[0] = '0;
    assign w_probe_pos[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ust_cell #(
            .IDX        (g),
            .ITEM_WIDTH (ITEM_WIDTH),
            .AW         (AW),
            .CW         (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr         (w_wr),
            .i_wr_addr    (w_wr_addr),
            .i_wr_data    (w_wr_data),
            .i_prev_entry (w_entry[(g == 0) ? 0 : g - 1]),
            .i_by_value   (r_by_value),
            .i_key        (r_key),
            .i_target     (r_target),
            .i_count      (r_count),
            .i_probe      (w_probe_ctl[g]),
            .i_probe_item (w_probe_item[g]),
            .i_probe_last (w_probe_last[g]),
            .i_probe_pos  (w_probe_pos[g]),
            .o_probe      (w_probe_ctl[g+1]),
            .o_probe_item (w_probe_item[g+1]),
            .o_probe_last (w_probe_last[g+1]),
            .o_probe_pos  (w_probe_pos[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_skip      = r_skip;
        n_func      = r_func;
        n_key       = r_key;
        n_target    = r_target;
        n_by_value  = r_by_value;
        n_launch    = 1'b0;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        w_wr        = '0;
        w_wr_addr   = w_probe_pos[CAPACITY];
        w_wr_data   = w_probe_last[CAPACITY];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func      = i_req.func;
                    n_key       = w_key_in;
                    n_rsp_valid = 1'b1;
                    n_rsp       = f_rsp(ust_pkg::ST_FAIL, ust_pkg::EV_NONE, '0, '0, 1'b0,
                                        r_count, 1'b1);
                    unique case (i_req.func) inside
                        ust_pkg::FN_APPEND: begin
                            if (r_count < CW'(CAPACITY)) begin
                                w_wr.en   = 1'b1;
                                w_wr_addr = AW'(r_count);
                                w_wr_data = w_key_in;
                                n_count   = r_count + CW'(1);
                                n_rsp     = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_INSERT,
                                                  w_key_in, AW'(r_count), 1'b0, n_count,
                                                  1'b1);
                            end
                        end
                        ust_pkg::FN_DELETE: begin
                            if (IW'(i_req.index) < IW'(r_count)) begin
                                n_rsp_valid = 1'b0;
                                n_target    = AW'(i_req.index);
                                n_by_value  = 1'b0;
                                n_launch    = 1'b1;
                                n_state     = S_SWEEP;
                            end
                        end
                        ust_pkg::FN_REMOVE, ust_pkg::FN_CONTAINS: begin
                            n_rsp_valid = 1'b0;
                            n_by_value  = 1'b1;
                            n_launch    = 1'b1;
                            n_state     = S_SWEEP;
                        end
                        ust_pkg::FN_TAKE: begin
                            if (r_count != '0) begin
                                n_rsp_valid = 1'b0;
                                n_by_value  = 1'b0;
                                n_state     = S_MOD;
                            end
                        end
                        ust_pkg::FN_CLEAR: begin
                            n_cursor = '0;
                            if (r_count == '0) begin
                                n_rsp = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_NONE, '0, '0,
                                              1'b0, '0, 1'b1);
                            end else begin
                                // slot 0 goes first, the rest leave from the top end
                                n_count = r_count - CW'(1);
                                n_skip  = CW'(CAPACITY) - r_count;
                                n_rsp   = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_REMOVE,
                                                w_entry[0], '0, 1'b0, n_count,
                                                (r_count == CW'(1)));
                                if (r_count != CW'(1)) begin
                                    n_state = S_CLEAR;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                // one subtract step per cycle
                if (r_cursor >= r_count) begin
                    n_cursor = r_cursor - r_count;
                end else begin
                    n_cursor = r_cursor;
                    n_target = AW'(r_cursor);
                    n_launch = 1'b1;
                    n_state  = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_probe_ctl[CAPACITY].valid) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                    if (r_func == ust_pkg::FN_CONTAINS) begin
                        n_rsp = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_NONE, '0, '0,
                                      w_probe_ctl[CAPACITY].hit, r_count, 1'b1);
                    end else if (!w_probe_ctl[CAPACITY].hit) begin
                        n_rsp = f_rsp(ust_pkg::ST_FAIL, ust_pkg::EV_NONE, '0, '0, 1'b0,
                                      r_count, 1'b1);
                    end else begin
                        // last entry fills the freed slot
                        w_wr.en = 1'b1;
                        n_count = r_count - CW'(1);
                        n_rsp   = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_REMOVE,
                                        w_probe_item[CAPACITY], w_probe_pos[CAPACITY],
                                        1'b0, n_count, 1'b1);
                        if (r_func == ust_pkg::FN_TAKE) begin
                            n_cursor = CW'(w_probe_pos[CAPACITY]) + CW'(1);
                        end
                    end
                end
            end
            S_CLEAR: begin
                // whole row moves up one slot per cycle
                w_wr.shift = 1'b1;
                if (r_skip != '0) begin
                    n_skip = r_skip - CW'(1);
                end else begin
                    n_count     = r_count - CW'(1);
                    n_rsp_valid = 1'b1;
                    n_rsp       = f_rsp(ust_pkg::ST_OK, ust_pkg::EV_REMOVE,
                                        w_entry[CAPACITY-1], '0, 1'b0, n_count,
                                        (r_count == CW'(1)));
                    if (r_count == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_launch    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_launch    <= n_launch;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip     <= n_skip;
        r_func     <= n_func;
        r_key      <= n_key;
        r_target   <= n_target;
        r_by_value <= n_by_value;
        r_rsp      <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_probe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe_ctl[CAPACITY].valid |-> (r_state == S_SWEEP))
        else $error("search token left the row outside a search");

    a_index_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_probe_ctl[CAPACITY].valid && !r_by_value) |-> w_probe_ctl[CAPACITY].hit)
        else $error("slot addressed by position was not found");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.last_in_run) |-> (r_state == S_CLEAR))
        else $error("non-final result outside a clear run");

endmodule

`default_nettype wire
